>>> design/shi_tomasi_corner_score_assert.svh
// Assertion macros shared by the corner score design.
`ifndef SHI_TOMASI_CORNER_SCORE_ASSERT_SVH
`define SHI_TOMASI_CORNER_SCORE_ASSERT_SVH

// same-cycle implication
`define STC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("corner score assertion failed");

// next-cycle implication
`define STC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("corner score assertion failed");

`endif

>>> design/stc_pkg.sv
package stc_pkg;

   localparam int PIXEL_W     = 8;
   localparam int GRAD_W      = 11;
   localparam int SCORE_W     = 24;
   localparam int COORD_W     = 10;
   localparam int DIM_CFG_W   = 11;
   localparam int SCALE_W     = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int DIM_CMP_W   = 13;
   localparam int DIM_MIN     = 5;

   localparam int MAX_COLS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT = 1024;

   localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [SCALE_W-1:0]   SCALE_RESET  = 16'd7282;

   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TENSOR_SCALE = 2'd2;

   localparam logic [SCORE_W-1:0] SCORE_SAT = 24'hFFFFFF;

endpackage

>>> design/stc_if.sv
interface stc_req_if import stc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface stc_rsp_if import stc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score_q4;
   logic [COORD_W-1:0] center_row;
   logic [COORD_W-1:0] center_col;
   logic [SCORE_W-1:0] frame_max_q4;
   logic               frame_last;
   modport source (output valid, output score_q4, output center_row, output center_col,
                   output frame_max_q4, output frame_last, input ready);
   modport sink   (input valid, input score_q4, input center_row, input center_col,
                   input frame_max_q4, input frame_last, output ready);
endinterface

interface stc_csr_if import stc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/shi_tomasi_corner_score.sv
// Shi-Tomasi corner score over a raster stream of 8-bit grey pixels.
// req_if carries one pixel per transfer, raster order, frame after frame.
// rsp_if carries at most one score per pixel: the minimum eigenvalue of the
// 3x3 Sobel structure tensor centred two rows and two columns back, its
// centre coordinates, the running frame maximum and a last-of-frame flag.
// csr_if writes frame_width (0), frame_height (1) and tensor_scale (2, unsigned Q4.12);
// write only while the block is idle. A geometry write restarts the frame.
// A pixel that yields no tensor work passes the idle and gradient states only;
// one that yields column sums only also runs the multiplier steps up to the
// column-sum update, and one that yields a score has one shared 30x30
// multiplier run 16 steps (14 products), then a restoring square root.
// Line stores are two single-port memories of MAX_COLS entries with registered
// reads; a pixel writes back both entries it reads (gradient: row, col >= 2).
// Reset puts the counters at frame start and restores the register defaults;
// no clearing pass is needed. The result sits in an output register; a new
// pixel is taken while it waits, and a stalled receiver holds the block only
// when the next score is ready and the register is still full.
`include "shi_tomasi_corner_score_assert.svh"

module shi_tomasi_corner_score
   import stc_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   stc_req_if.sink    req_if,
   stc_rsp_if.source  rsp_if,
   stc_csr_if.sink    csr_if
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int WW = CW + 1;
   localparam int HW = RW + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GRAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;

   logic [DIM_CFG_W-1:0] width_ff, height_ff;
   logic [SCALE_W-1:0]   scale_ff;

   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [SCORE_W-1:0] max_ff;

   logic [PIXEL_W-1:0] pix_ff;
   logic [PIXEL_W-1:0] pc1_ff [3];
   logic [PIXEL_W-1:0] pc2_ff [3];

   logic [2*PIXEL_W-1:0] pix_mem [MAX_COLS];
   logic [4*GRAD_W-1:0]  grad_mem [MAX_COLS];
   logic [2*PIXEL_W-1:0] pix_rd_ff;
   logic [4*GRAD_W-1:0]  grad_rd_ff;

   logic signed [GRAD_W-1:0] gx_ff, gy_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [25:0] cxx_ff, cxy_ff, cyy_ff;
   logic signed [25:0] cs0_ff [3];
   logic signed [25:0] cs1_ff [3];
   logic [23:0] sxx_ff, sxy_ff, syy_ff;
   logic [27:0] a_ff, c_ff, b_ff, d_ff;
   logic [28:0] tr_ff;
   logic [59:0] rad_ff;
   logic [31:0] rem_ff;
   logic [29:0] root_ff;

   logic rsp_valid_ff;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_max_ff;
   logic [COORD_W-1:0] rsp_row_ff, rsp_col_ff;
   logic rsp_last_ff;

   logic req_xfer, csr_xfer, rsp_free;
   logic [WW-1:0] dim_w;
   logic [HW-1:0] dim_h;
   logic [DIM_CMP_W-1:0] w_ext, h_ext;
   logic [CW-1:0] gcol;
   logic signed [11:0] gx_wide, gy_wide;
   logic signed [GRAD_W-1:0] gx_new, gy_new;
   logic signed [29:0] mul_a, mul_b;
   logic signed [59:0] prod;
   logic signed [25:0] sum_xx, sum_xy, sum_yy;
   logic [33:0] rem_t, trial;
   logic [29:0] score_raw;
   logic [SCORE_W-1:0] score;
   logic [SCORE_W-1:0] max_new;
   logic last_pix;
   logic advance;
   logic [RW-1:0] row_m2;
   logic [CW-1:0] col_m2;

   assign req_xfer = req_if.valid && req_if.ready;
   assign csr_xfer = csr_if.valid && csr_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      w_ext = DIM_CMP_W'(width_ff);
      h_ext = DIM_CMP_W'(height_ff);
      if (w_ext < DIM_CMP_W'(DIM_MIN)) begin
         dim_w = WW'(DIM_MIN);
      end else if (w_ext > DIM_CMP_W'(MAX_COLS)) begin
         dim_w = WW'(MAX_COLS);
      end else begin
         dim_w = WW'(w_ext);
      end
      if (h_ext < DIM_CMP_W'(DIM_MIN)) begin
         dim_h = HW'(DIM_MIN);
      end else if (h_ext > DIM_CMP_W'(MAX_ROWS)) begin
         dim_h = HW'(MAX_ROWS);
      end else begin
         dim_h = HW'(h_ext);
      end
   end

   assign gcol = col_ff - CW'(1);
   assign last_pix = ({1'b0, row_ff} + HW'(1) == dim_h) && ({1'b0, col_ff} + WW'(1) == dim_w);

   always_comb begin
      gx_wide = 12'(pix_rd_ff[15:8]) + 12'({pix_rd_ff[7:0], 1'b0}) + 12'(pix_ff)
              - 12'(pc2_ff[0]) - 12'({pc2_ff[1], 1'b0}) - 12'(pc2_ff[2]);
      gy_wide = 12'(pc2_ff[2]) + 12'({pc1_ff[2], 1'b0}) + 12'(pix_ff)
              - 12'(pc2_ff[0]) - 12'({pc1_ff[0], 1'b0}) - 12'(pix_rd_ff[15:8]);
      gx_new = GRAD_W'(gx_wide);
      gy_new = GRAD_W'(gy_wide);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         5'd0:    begin mul_a = 30'(x2_ff); mul_b = 30'(x2_ff); end
         5'd1:    begin mul_a = 30'(x1_ff); mul_b = 30'(x1_ff); end
         5'd2:    begin mul_a = 30'(gx_ff); mul_b = 30'(gx_ff); end
         5'd3:    begin mul_a = 30'(x2_ff); mul_b = 30'(y2_ff); end
         5'd4:    begin mul_a = 30'(x1_ff); mul_b = 30'(y1_ff); end
         5'd5:    begin mul_a = 30'(gx_ff); mul_b = 30'(gy_ff); end
         5'd6:    begin mul_a = 30'(y2_ff); mul_b = 30'(y2_ff); end
         5'd7:    begin mul_a = 30'(y1_ff); mul_b = 30'(y1_ff); end
         5'd8:    begin mul_a = 30'(gy_ff); mul_b = 30'(gy_ff); end
         5'd10:   begin mul_a = 30'(sxx_ff); mul_b = 30'(scale_ff); end
         5'd11:   begin mul_a = 30'(syy_ff); mul_b = 30'(scale_ff); end
         5'd12:   begin mul_a = 30'(sxy_ff); mul_b = 30'(scale_ff); end
         5'd14:   begin mul_a = 30'(d_ff); mul_b = 30'(d_ff); end
         5'd15:   begin mul_a = 30'(b_ff); mul_b = 30'(b_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      sum_xx = cxx_ff + cs0_ff[0] + cs1_ff[0];
      sum_xy = cxy_ff + cs0_ff[1] + cs1_ff[1];
      sum_yy = cyy_ff + cs0_ff[2] + cs1_ff[2];
   end

   assign rem_t = {rem_ff, rad_ff[59:58]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      if ({1'b0, tr_ff} >= root_ff) begin
         score_raw = ({1'b0, tr_ff} - root_ff) >> 1;
      end else begin
         score_raw = '0;
      end
      score = (score_raw > 30'(SCORE_SAT)) ? SCORE_SAT : SCORE_W'(score_raw);
      max_new = (score > max_ff) ? score : max_ff;
      row_m2 = row_ff - RW'(2);
      col_m2 = col_ff - CW'(2);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_GRAD;
            end
         end
         ST_GRAD: begin
            if (row_ff >= RW'(4) && col_ff >= CW'(2)) begin
               state_in = ST_MUL;
               step_in = '0;
            end else begin
               state_in = ST_IDLE;
               advance = 1'b1;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd9 && col_ff < CW'(4)) begin
               state_in = ST_IDLE;
               advance = 1'b1;
            end else if (step_ff == 5'd15) begin
               state_in = ST_SQRT;
               step_in = '0;
            end
         end
         ST_SQRT: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd29) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
               advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         scale_ff <= SCALE_RESET;
         col_ff <= '0;
         row_ff <= '0;
         max_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         if (csr_xfer) begin
            unique case (csr_if.index)
               REG_FRAME_WIDTH: begin
                  width_ff <= csr_if.data[DIM_CFG_W-1:0];
                  col_ff <= '0;
                  row_ff <= '0;
                  max_ff <= '0;
               end
               REG_FRAME_HEIGHT: begin
                  height_ff <= csr_if.data[DIM_CFG_W-1:0];
                  col_ff <= '0;
                  row_ff <= '0;
                  max_ff <= '0;
               end
               REG_TENSOR_SCALE: begin
                  scale_ff <= csr_if.data[SCALE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_xfer && row_ff == '0 && col_ff == '0) begin
            max_ff <= '0;
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            max_ff <= max_new;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            if ({1'b0, col_ff} + WW'(1) >= dim_w) begin
               col_ff <= '0;
               row_ff <= ({1'b0, row_ff} + HW'(1) >= dim_h) ? '0 : row_ff + RW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pix_ff <= req_if.pixel;
         pix_rd_ff <= pix_mem[col_ff];
         grad_rd_ff <= grad_mem[gcol];
      end
      if (state_ff == ST_GRAD) begin
         pix_mem[col_ff] <= {pix_rd_ff[7:0], pix_ff};
         if (row_ff >= RW'(2) && col_ff >= CW'(2)) begin
            grad_mem[gcol] <= {grad_rd_ff[21:0], gx_new, gy_new};
         end
         x2_ff <= grad_rd_ff[43:33];
         y2_ff <= grad_rd_ff[32:22];
         x1_ff <= grad_rd_ff[21:11];
         y1_ff <= grad_rd_ff[10:0];
         gx_ff <= gx_new;
         gy_ff <= gy_new;
         pc2_ff <= pc1_ff;
         pc1_ff[0] <= pix_rd_ff[15:8];
         pc1_ff[1] <= pix_rd_ff[7:0];
         pc1_ff[2] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         case (step_ff)
            5'd0: cxx_ff <= 26'(prod);
            5'd1, 5'd2: cxx_ff <= cxx_ff + 26'(prod);
            5'd3: cxy_ff <= 26'(prod);
            5'd4, 5'd5: cxy_ff <= cxy_ff + 26'(prod);
            5'd6: cyy_ff <= 26'(prod);
            5'd7, 5'd8: cyy_ff <= cyy_ff + 26'(prod);
            5'd9: begin
               sxx_ff <= 24'(sum_xx);
               sxy_ff <= 24'((sum_xy < 0) ? -sum_xy : sum_xy);
               syy_ff <= 24'(sum_yy);
               cs1_ff <= cs0_ff;
               cs0_ff[0] <= cxx_ff;
               cs0_ff[1] <= cxy_ff;
               cs0_ff[2] <= cyy_ff;
            end
            5'd10: a_ff <= prod[39:12];
            5'd11: c_ff <= prod[39:12];
            5'd12: b_ff <= prod[39:12];
            5'd13: begin
               d_ff <= (a_ff > c_ff) ? a_ff - c_ff : c_ff - a_ff;
               tr_ff <= {1'b0, a_ff} + {1'b0, c_ff};
            end
            5'd14: rad_ff <= {4'b0000, prod[55:0]};
            5'd15: begin
               rad_ff <= rad_ff + {2'b00, prod[55:0], 2'b00};
               rem_ff <= '0;
               root_ff <= '0;
            end
            default: begin
            end
         endcase
      end
      if (state_ff == ST_SQRT) begin
         rad_ff <= {rad_ff[57:0], 2'b00};
         if (rem_t >= trial) begin
            rem_ff <= 32'(rem_t - trial);
            root_ff <= {root_ff[28:0], 1'b1};
         end else begin
            rem_ff <= 32'(rem_t);
            root_ff <= {root_ff[28:0], 1'b0};
         end
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_score_ff <= score;
         rsp_max_ff <= max_new;
         rsp_row_ff <= COORD_W'(row_m2);
         rsp_col_ff <= COORD_W'(col_m2);
         rsp_last_ff <= last_pix;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.score_q4     = rsp_score_ff;
   assign rsp_if.frame_max_q4 = rsp_max_ff;
   assign rsp_if.center_row   = rsp_row_ff;
   assign rsp_if.center_col   = rsp_col_ff;
   assign rsp_if.frame_last   = rsp_last_ff;

   `STC_ASSERT_NOW(a_score_le_max, clock, reset, rsp_valid_ff, rsp_score_ff <= rsp_max_ff)
   `STC_ASSERT_NEXT(a_geom_restart, clock, reset,
      csr_xfer && (csr_if.index == REG_FRAME_WIDTH || csr_if.index == REG_FRAME_HEIGHT),
      col_ff == '0 && row_ff == '0 && max_ff == '0)
   `STC_ASSERT_NEXT(a_frame_start_clear, clock, reset,
      req_xfer && row_ff == '0 && col_ff == '0, max_ff == '0)

endmodule

>>> verif/tb_shi_tomasi_corner_score.sv
module tb_shi_tomasi_corner_score;
   import stc_pkg::*;

   typedef struct {
      logic [SCORE_W-1:0] score;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [SCORE_W-1:0] fmax;
      logic               last;
   } corner_type;

   localparam int NCOLS = MAX_COLS_DEFAULT;
   localparam int NROWS = MAX_ROWS_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int ITEM_TARGET = 900;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stc_req_if req_if ();
   stc_rsp_if rsp_if ();
   stc_csr_if csr_if ();

   shi_tomasi_corner_score dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [PIXEL_W-1:0] pixel_queue[$];
   corner_type         corner_queue[$];
   bit                 calm = 1'b1;
   int                 failures = 0;
   int                 stall_cycles = 0;

   // scoring state, kept apart from the block
   logic [DIM_CFG_W-1:0] width_reg = WIDTH_RESET;
   logic [DIM_CFG_W-1:0] height_reg = HEIGHT_RESET;
   logic [SCALE_W-1:0]   scale_reg = SCALE_RESET;
   int                   pix_row1[NCOLS];
   int                   pix_row0[NCOLS];
   int                   gx_row1[NCOLS];
   int                   gx_row0[NCOLS];
   int                   gy_row1[NCOLS];
   int                   gy_row0[NCOLS];
   int                   csum1[3];
   int                   csum0[3];
   int                   win_col1[3];
   int                   win_col2[3];
   int                   cur_row = 0;
   int                   cur_col = 0;
   longint unsigned      peak = 0;

   function automatic int clamp_dim(int v, int hi);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned min_eigen(int sxx, int sxy, int syy);
      longint unsigned sc, bm, a, c, b, d, root, tr, s;
      sc = scale_reg;
      bm = (sxy < 0) ? longint'(-sxy) : longint'(sxy);
      a = (longint'(sxx) * sc) >> 12;
      c = (longint'(syy) * sc) >> 12;
      b = (bm * sc) >> 12;
      d = (a > c) ? a - c : c - a;
      root = int_sqrt(d * d + 4 * b * b);
      tr = a + c;
      s = (tr >= root) ? (tr - root) >> 1 : 0;
      return (s > SCORE_SAT) ? longint'(SCORE_SAT) : s;
   endfunction

   task automatic score_pixel(input logic [PIXEL_W-1:0] pix);
      int w, h, r, c, ci, gi, gx, gy, x1, x2, y1, y2, cxx, cxy, cyy;
      int ncol[3];
      longint unsigned s;
      corner_type e;
      w = clamp_dim(int'(width_reg), NCOLS);
      h = clamp_dim(int'(height_reg), NROWS);
      r = cur_row;
      c = cur_col;
      ci = (c < NCOLS) ? c : NCOLS - 1;
      if (r == 0 && c == 0) peak = 0;
      ncol[0] = pix_row1[ci];
      ncol[1] = pix_row0[ci];
      ncol[2] = int'(pix);
      pix_row1[ci] = ncol[1];
      pix_row0[ci] = ncol[2];
      if (r >= 2 && c >= 2) begin
         gx = (ncol[0] + 2 * ncol[1] + ncol[2]) - (win_col2[0] + 2 * win_col2[1] + win_col2[2]);
         gy = (win_col2[2] + 2 * win_col1[2] + ncol[2]) - (win_col2[0] + 2 * win_col1[0] + ncol[0]);
         gi = ci - 1;
         x2 = gx_row1[gi];
         y2 = gy_row1[gi];
         x1 = gx_row0[gi];
         y1 = gy_row0[gi];
         gx_row1[gi] = x1;
         gy_row1[gi] = y1;
         gx_row0[gi] = gx;
         gy_row0[gi] = gy;
         if (r >= 4) begin
            cxx = x2 * x2 + x1 * x1 + gx * gx;
            cxy = x2 * y2 + x1 * y1 + gx * gy;
            cyy = y2 * y2 + y1 * y1 + gy * gy;
            if (c >= 4) begin
               s = min_eigen(cxx + csum0[0] + csum1[0], cxy + csum0[1] + csum1[1],
                             cyy + csum0[2] + csum1[2]);
               if (s > peak) peak = s;
               e.score = SCORE_W'(s);
               e.row = COORD_W'(r - 2);
               e.col = COORD_W'(c - 2);
               e.fmax = SCORE_W'(peak);
               e.last = (r + 1 == h && c + 1 == w);
               corner_queue.insert(corner_queue.size(), e);
            end
            csum1 = csum0;
            csum0[0] = cxx;
            csum0[1] = cxy;
            csum0[2] = cyy;
         end
      end
      win_col2 = win_col1;
      win_col1 = ncol;
      if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
      end
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.pixel <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            score_pixel(req_if.pixel);
            void'(pixel_queue.pop_front());
         end
         if (!req_if.valid || req_if.ready) begin
            if (pixel_queue.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
               req_if.valid <= 1'b1;
               req_if.pixel <= pixel_queue[0];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // score monitor and watchdog
   always @(posedge clock) begin
      corner_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || $urandom_range(99) >= 20;
         if (rsp_if.valid && rsp_if.ready) begin
            if (corner_queue.size() == 0) begin
               $error("unexpected score at row %0d col %0d", rsp_if.center_row,
                      rsp_if.center_col);
               failures++;
            end else begin
               e = corner_queue.pop_front();
               if (rsp_if.score_q4 !== e.score) begin
                  $error("score_q4 exp %0d got %0d", e.score, rsp_if.score_q4);
                  failures++;
               end
               if (rsp_if.center_row !== e.row) begin
                  $error("center_row exp %0d got %0d", e.row, rsp_if.center_row);
                  failures++;
               end
               if (rsp_if.center_col !== e.col) begin
                  $error("center_col exp %0d got %0d", e.col, rsp_if.center_col);
                  failures++;
               end
               if (rsp_if.frame_max_q4 !== e.fmax) begin
                  $error("frame_max_q4 exp %0d got %0d", e.fmax, rsp_if.frame_max_q4);
                  failures++;
               end
               if (rsp_if.frame_last !== e.last) begin
                  $error("frame_last exp %0d got %0d", e.last, rsp_if.frame_last);
                  failures++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
         if (idx == REG_FRAME_WIDTH) width_reg = val[DIM_CFG_W-1:0];
         else height_reg = val[DIM_CFG_W-1:0];
         cur_row = 0;
         cur_col = 0;
         peak = 0;
      end else if (idx == REG_TENSOR_SCALE) begin
         scale_reg = val;
      end
   endtask

   task automatic drain();
      while (pixel_queue.size() > 0 || corner_queue.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic run_frame(input int w, input int h, input int scale, input int n,
                            input int style);
      int i;
      logic [PIXEL_W-1:0] p;
      write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_TENSOR_SCALE, CSR_DATA_W'(scale));
      for (i = 0; i < n; i++) begin
         case (style)
            0: p = PIXEL_W'($urandom_range(255));
            1: p = ($urandom_range(1)) ? 8'hFF : 8'h00;
            default: p = PIXEL_W'((i % 7) * 30 + $urandom_range(15));
         endcase
         pixel_queue.insert(pixel_queue.size(), p);
      end
      drain();
   endtask

   initial begin
      int done, w, h, n, sc, pick;
      req_if.valid = 1'b0;
      req_if.pixel = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // checkerboard frame, full scale: the Sobel gradients cancel, so the score is zero
      calm = 1'b1;
      write_reg(REG_FRAME_WIDTH, 5);
      write_reg(REG_FRAME_HEIGHT, 5);
      write_reg(REG_TENSOR_SCALE, 16'hFFFF);
      for (int i = 0; i < 25; i++)
         pixel_queue.insert(pixel_queue.size(),
                            ((i / 5 + i % 5) % 2) ? 8'hFF : 8'h00);
      drain();

      run_frame(16'hFFFF, 5, 7282, 200, 0);
      run_frame(5, NROWS, 1, 200, 0);
      run_frame(0, 0, 0, 50, 1);
      write_reg(REG_SPARE, 16'hFFFF);

      done = 25 + 200 + 200 + 50;
      while (done < ITEM_TARGET) begin
         calm = ($urandom_range(3) == 0);
         w = $urandom_range(12, 5);
         h = $urandom_range(10, 5);
         pick = $urandom_range(5);
         sc = (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : (pick == 2) ? 1 :
              (pick == 3) ? 7282 : $urandom_range(65535);
         n = w * h * $urandom_range(2, 1);
         if ($urandom_range(4) == 0) n = $urandom_range(w * h);
         run_frame(w, h, sc, n, $urandom_range(2));
         done += n;
      end

      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
